/* rtl/touch_gesture_recognizer_assert.svh */
// assertion macros for the touch gesture recognizer
`ifndef TOUCH_GESTURE_RECOGNIZER_ASSERT_SVH
`define TOUCH_GESTURE_RECOGNIZER_ASSERT_SVH

// same-cycle implication, checked on aclk outside reset
`define TGR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on aclk outside reset
`define TGR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/tgr_pkg.sv */
// shared constants and types for the touch gesture recognizer
package tgr_pkg;

    localparam int TIME_FIELD_W = 32;
    localparam int FINGER_W     = 4;
    localparam int ACT_W        = 3;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int PX_CFG_W     = 8;
    localparam int MS_CFG_W     = 16;

    typedef logic [ACT_W-1:0] action_t;

    // event codes, directions share the low codes
    localparam action_t ACT_UP    = 3'd0;
    localparam action_t ACT_RIGHT = 3'd1;
    localparam action_t ACT_DOWN  = 3'd2;
    localparam action_t ACT_LEFT  = 3'd3;
    localparam action_t ACT_TAP   = 3'd4;
    localparam action_t ACT_MENU  = 3'd5;
    localparam action_t DIR_NONE  = 3'd7;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_START_THRESHOLD = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SWIPE_DISTANCE  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PERP_CANCEL     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SWIPE_TIMEOUT   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_INTERVAL = 3'd5;

    // register reset values
    localparam logic [PX_CFG_W-1:0] START_THRESHOLD_RST = 8'd8;
    localparam logic [PX_CFG_W-1:0] SWIPE_DISTANCE_RST  = 8'd40;
    localparam logic [PX_CFG_W-1:0] PERP_CANCEL_RST     = 8'd32;
    localparam logic [MS_CFG_W-1:0] SWIPE_TIMEOUT_RST   = 16'd1000;
    localparam logic [MS_CFG_W-1:0] LONG_PRESS_RST      = 16'd700;
    localparam logic [MS_CFG_W-1:0] REPEAT_INTERVAL_RST = 16'd50;

    // shortest repeat interval actually used
    localparam logic [MS_CFG_W-1:0] REPEAT_FLOOR_MS = 16'd50;

endpackage

/* rtl/touch_gesture_recognizer.sv */
// touch gesture recognizer: swipe, tap, long press, menu and held-swipe repeats
//
// channel   dir  handshake            payload
// s_        in   s_tvalid / s_tready   tdata pos_x, pos_y, finger_count, time_ms; tuser is_touching
// m_        out  m_tvalid / m_tready   tdata event_x, event_y; tuser action
// cfg_      in   cfg_valid / cfg_ready register index and 16-bit write data
//
// one item per cycle sustained while m_tready does not hold back a result; an accepted item
// waits in the input register, the gesture step runs between that register and the result
// register, and a result, if the step emits one, is registered when its item is stepped
// a held result stalls only the step; one more item is still taken into the input register
// aresetn is synchronous, active low; it clears control state and loads register defaults
// cfg_ready is always high, a write lands at its accepting edge
`include "touch_gesture_recognizer_assert.svh"

module touch_gesture_recognizer
    import tgr_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int TIME_BITS  = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_tvalid,
    output logic                                s_tready,
    // pos_x, pos_y, finger_count, time_ms, zero pad
    input  logic [((2*COORD_BITS+FINGER_W+TIME_FIELD_W+7)/8)*8-1:0] s_tdata,
    // is_touching
    input  logic                                s_tuser,

    output logic                                m_tvalid,
    input  logic                                m_tready,
    // event_x, event_y, zero pad
    output logic [((2*COORD_BITS+7)/8)*8-1:0]   m_tdata,
    // action
    output logic [ACT_W-1:0]                    m_tuser,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [CFG_INDEX_W-1:0]              cfg_index,
    input  logic [CFG_DATA_W-1:0]               cfg_data
);

    localparam int M_DATA_W = ((2*COORD_BITS+7)/8)*8;
    // signed width that holds coordinate differences and 8-bit thresholds
    localparam int CMP_W    = ((COORD_BITS > PX_CFG_W) ? COORD_BITS : PX_CFG_W) + 2;
    localparam int Y_LO     = COORD_BITS;
    localparam int FC_LO    = 2*COORD_BITS;
    localparam int T_LO     = 2*COORD_BITS + FINGER_W;

    typedef logic [COORD_BITS-1:0]   coord_t;
    typedef logic [TIME_BITS-1:0]    tstamp_t;
    typedef logic signed [CMP_W-1:0] scmp_t;

    // dominant direction of a displacement
    function automatic action_t dominant(input scmp_t dx, input scmp_t dy,
                                         input scmp_t adx, input scmp_t ady);
        action_t d;
        if (adx >= ady) begin
            if (dx > 0) d = ACT_RIGHT;
            else if (dx < 0) d = ACT_LEFT;
            else d = DIR_NONE;
        end else begin
            d = (dy > 0) ? ACT_DOWN : ACT_UP;
        end
        return d;
    endfunction

    // progress along a direction
    function automatic scmp_t progress(input action_t d, input scmp_t dx, input scmp_t dy);
        scmp_t p;
        case (d)
            ACT_UP:    p = -dy;
            ACT_RIGHT: p = dx;
            ACT_DOWN:  p = dy;
            ACT_LEFT:  p = -dx;
            default:   p = '0;
        endcase
        return p;
    endfunction

    // configuration registers
    logic [PX_CFG_W-1:0] start_threshold_reg, swipe_distance_reg, perp_cancel_reg;
    logic [MS_CFG_W-1:0] swipe_timeout_reg, long_press_reg, repeat_interval_reg;

    // input register
    logic                    in_valid_reg;
    coord_t                  in_x_reg, in_y_reg;
    logic [FINGER_W-1:0]     in_fc_reg;
    logic                    in_touch_reg;
    logic [TIME_FIELD_W-1:0] in_time_reg;

    // gesture state
    logic                touch_active_reg, touch_active_next;
    logic                swipe_allowed_reg, swipe_allowed_next;
    logic                gesture_done_reg, gesture_done_next;
    logic                repeat_active_reg, repeat_active_next;
    action_t             locked_dir_reg, locked_dir_next;
    coord_t              start_x_reg, start_x_next, start_y_reg, start_y_next;
    coord_t              latest_x_reg, latest_x_next, latest_y_reg, latest_y_next;
    logic [FINGER_W-1:0] press_fingers_reg, press_fingers_next;
    tstamp_t             press_time_reg, press_time_next;
    action_t             repeat_move_reg, repeat_move_next;
    coord_t              rep_x_reg, rep_x_next, rep_y_reg, rep_y_next;
    tstamp_t             last_rep_time_reg, last_rep_time_next;

    // result register
    logic    m_valid_reg, m_valid_next;
    action_t m_action_reg;
    coord_t  m_x_reg, m_y_reg;

    logic    s_accept, proc_fire;
    logic    emit;
    action_t emit_act;
    coord_t  emit_x, emit_y;

    // step datapath
    coord_t  px, py;
    tstamp_t t_now, dt_press, dt_rep;
    scmp_t   dx, dy, adx, ady, cheb;
    scmp_t   rdx, rdy, ardx, ardy, rcheb;
    scmp_t   need, thr, pcancel, perp_lock, prog_lock, prog_dom;
    action_t dom, sw_dir;
    logic    sw_use_lock, sw_ok;
    logic [MS_CFG_W-1:0] rep_iv;

    // back-pressure: the input register frees up when its item is stepped
    assign proc_fire = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || proc_fire;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_action_reg;
    assign m_tdata  = M_DATA_W'({m_y_reg, m_x_reg});

    // configuration writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_threshold_reg <= START_THRESHOLD_RST;
            swipe_distance_reg  <= SWIPE_DISTANCE_RST;
            perp_cancel_reg     <= PERP_CANCEL_RST;
            swipe_timeout_reg   <= SWIPE_TIMEOUT_RST;
            long_press_reg      <= LONG_PRESS_RST;
            repeat_interval_reg <= REPEAT_INTERVAL_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_START_THRESHOLD: start_threshold_reg <= cfg_data[PX_CFG_W-1:0];
                REG_SWIPE_DISTANCE:  swipe_distance_reg  <= cfg_data[PX_CFG_W-1:0];
                REG_PERP_CANCEL:     perp_cancel_reg     <= cfg_data[PX_CFG_W-1:0];
                REG_SWIPE_TIMEOUT:   swipe_timeout_reg   <= cfg_data;
                REG_LONG_PRESS:      long_press_reg      <= cfg_data;
                REG_REPEAT_INTERVAL: repeat_interval_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (proc_fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_x_reg     <= s_tdata[COORD_BITS-1:0];
            in_y_reg     <= s_tdata[Y_LO +: COORD_BITS];
            in_fc_reg    <= s_tdata[FC_LO +: FINGER_W];
            in_time_reg  <= s_tdata[T_LO +: TIME_FIELD_W];
            in_touch_reg <= s_tuser;
        end
    end

    // geometry: on release the last touched point is evaluated
    assign px    = in_touch_reg ? in_x_reg : latest_x_reg;
    assign py    = in_touch_reg ? in_y_reg : latest_y_reg;
    assign dx    = scmp_t'(px) - scmp_t'(start_x_reg);
    assign dy    = scmp_t'(py) - scmp_t'(start_y_reg);
    assign adx   = (dx < 0) ? -dx : dx;
    assign ady   = (dy < 0) ? -dy : dy;
    assign cheb  = (adx > ady) ? adx : ady;
    assign dom   = dominant(dx, dy, adx, ady);

    // drift from the repeat origin
    assign rdx   = scmp_t'(in_x_reg) - scmp_t'(rep_x_reg);
    assign rdy   = scmp_t'(in_y_reg) - scmp_t'(rep_y_reg);
    assign ardx  = (rdx < 0) ? -rdx : rdx;
    assign ardy  = (rdy < 0) ? -rdy : rdy;
    assign rcheb = (ardx > ardy) ? ardx : ardy;

    assign need    = scmp_t'(swipe_distance_reg);
    assign thr     = scmp_t'(start_threshold_reg);
    assign pcancel = scmp_t'(perp_cancel_reg);

    assign prog_lock = progress(locked_dir_reg, dx, dy);
    assign prog_dom  = progress(dom, dx, dy);
    assign perp_lock = (locked_dir_reg == ACT_UP || locked_dir_reg == ACT_DOWN) ? adx :
                       (locked_dir_reg == ACT_RIGHT || locked_dir_reg == ACT_LEFT) ? ady :
                       scmp_t'(0);

    // swipe recognition: locked direction if it got far enough, else the dominant one
    assign sw_use_lock = (locked_dir_reg != DIR_NONE) && !(prog_lock < need);
    assign sw_ok  = swipe_allowed_reg &&
                    (sw_use_lock || (!(cheb < need) && dom != DIR_NONE && !(prog_dom < need)));
    assign sw_dir = sw_use_lock ? locked_dir_reg : dom;

    // time differences wrap at the timestamp width
    assign t_now    = tstamp_t'(in_time_reg);
    assign dt_press = t_now - press_time_reg;
    assign dt_rep   = t_now - last_rep_time_reg;
    assign rep_iv   = (repeat_interval_reg < REPEAT_FLOOR_MS) ? REPEAT_FLOOR_MS
                                                              : repeat_interval_reg;

    // gesture step
    always_comb begin
        touch_active_next  = touch_active_reg;
        swipe_allowed_next = swipe_allowed_reg;
        gesture_done_next  = gesture_done_reg;
        repeat_active_next = repeat_active_reg;
        locked_dir_next    = locked_dir_reg;
        start_x_next       = start_x_reg;
        start_y_next       = start_y_reg;
        latest_x_next      = latest_x_reg;
        latest_y_next      = latest_y_reg;
        press_fingers_next = press_fingers_reg;
        press_time_next    = press_time_reg;
        repeat_move_next   = repeat_move_reg;
        rep_x_next         = rep_x_reg;
        rep_y_next         = rep_y_reg;
        last_rep_time_next = last_rep_time_reg;
        emit               = 1'b0;
        emit_act           = ACT_TAP;
        emit_x             = px;
        emit_y             = py;

        if (!in_touch_reg) begin
            // release
            if (touch_active_reg && !gesture_done_reg) begin
                if (press_fingers_reg >= FINGER_W'(2)) begin
                    emit     = 1'b1;
                    emit_act = ACT_MENU;
                end else if (sw_ok) begin
                    if (press_fingers_reg == FINGER_W'(1)) begin
                        emit               = 1'b1;
                        emit_act           = sw_dir;
                        repeat_move_next   = sw_dir;
                        rep_x_next         = px;
                        rep_y_next         = py;
                        last_rep_time_next = t_now;
                    end
                end else begin
                    emit     = 1'b1;
                    emit_act = (dt_press >= tstamp_t'(long_press_reg)) ? ACT_MENU : ACT_TAP;
                end
            end
            touch_active_next  = 1'b0;
            swipe_allowed_next = 1'b0;
            gesture_done_next  = 1'b0;
            repeat_active_next = 1'b0;
            locked_dir_next    = DIR_NONE;
        end else if (!touch_active_reg) begin
            // press: several fingers open the menu at once
            touch_active_next  = 1'b1;
            swipe_allowed_next = (in_fc_reg < FINGER_W'(2));
            gesture_done_next  = (in_fc_reg >= FINGER_W'(2));
            locked_dir_next    = DIR_NONE;
            start_x_next       = in_x_reg;
            start_y_next       = in_y_reg;
            latest_x_next      = in_x_reg;
            latest_y_next      = in_y_reg;
            press_fingers_next = in_fc_reg;
            press_time_next    = t_now;
            if (in_fc_reg >= FINGER_W'(2)) begin
                emit     = 1'b1;
                emit_act = ACT_MENU;
            end
        end else begin
            latest_x_next = in_x_reg;
            latest_y_next = in_y_reg;
            if (gesture_done_reg) begin
                // held swipe: re-aim on drift, repeat at the interval
                if (repeat_active_reg) begin
                    if (!(rcheb < need)) begin
                        rep_x_next = in_x_reg;
                        rep_y_next = in_y_reg;
                        if (dom != DIR_NONE) begin
                            repeat_move_next = dom;
                        end
                    end
                    if (!(dt_rep < tstamp_t'(rep_iv))) begin
                        last_rep_time_next = t_now;
                        emit               = 1'b1;
                        emit_act           = repeat_move_next;
                    end
                end
            end else if (swipe_allowed_reg) begin
                if (in_fc_reg < press_fingers_reg ||
                    dt_press > tstamp_t'(swipe_timeout_reg)) begin
                    swipe_allowed_next = 1'b0;
                end else if (locked_dir_reg == DIR_NONE) begin
                    if (cheb > thr) begin
                        locked_dir_next    = dom;
                        press_fingers_next = in_fc_reg;
                    end
                end else if (perp_lock > pcancel) begin
                    swipe_allowed_next = 1'b0;
                end else if (!(prog_lock < need) && sw_ok) begin
                    gesture_done_next  = 1'b1;
                    swipe_allowed_next = 1'b0;
                    if (press_fingers_reg == FINGER_W'(1)) begin
                        emit               = 1'b1;
                        emit_act           = sw_dir;
                        repeat_active_next = 1'b1;
                        repeat_move_next   = sw_dir;
                        rep_x_next         = in_x_reg;
                        rep_y_next         = in_y_reg;
                        last_rep_time_next = t_now;
                    end else if (press_fingers_reg >= FINGER_W'(2)) begin
                        emit     = 1'b1;
                        emit_act = ACT_MENU;
                    end
                end
            end
        end
    end

    // gesture control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            touch_active_reg  <= 1'b0;
            swipe_allowed_reg <= 1'b0;
            gesture_done_reg  <= 1'b0;
            repeat_active_reg <= 1'b0;
            locked_dir_reg    <= DIR_NONE;
            start_x_reg       <= '0;
            start_y_reg       <= '0;
            latest_x_reg      <= '0;
            latest_y_reg      <= '0;
            press_fingers_reg <= '0;
            press_time_reg    <= '0;
            repeat_move_reg   <= ACT_UP;
            rep_x_reg         <= '0;
            rep_y_reg         <= '0;
            last_rep_time_reg <= '0;
        end else if (proc_fire) begin
            touch_active_reg  <= touch_active_next;
            swipe_allowed_reg <= swipe_allowed_next;
            gesture_done_reg  <= gesture_done_next;
            repeat_active_reg <= repeat_active_next;
            locked_dir_reg    <= locked_dir_next;
            start_x_reg       <= start_x_next;
            start_y_reg       <= start_y_next;
            latest_x_reg      <= latest_x_next;
            latest_y_reg      <= latest_y_next;
            press_fingers_reg <= press_fingers_next;
            press_time_reg    <= press_time_next;
            repeat_move_reg   <= repeat_move_next;
            rep_x_reg         <= rep_x_next;
            rep_y_reg         <= rep_y_next;
            last_rep_time_reg <= last_rep_time_next;
        end
    end

    // result register
    assign m_valid_next = proc_fire ? emit : (m_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_fire && emit) begin
            m_action_reg <= emit_act;
            m_x_reg      <= emit_x;
            m_y_reg      <= emit_y;
        end
    end

    // a finished gesture never keeps swipe recognition open
    `TGR_ASSERT_SAME(a_done_blocks_swipe, gesture_done_reg, !swipe_allowed_reg,
                     "swipe still allowed after gesture finished")

    // repeats only run inside a finished, still held gesture
    `TGR_ASSERT_SAME(a_repeat_needs_hold, repeat_active_reg,
                     gesture_done_reg && touch_active_reg,
                     "repeat active outside a held gesture")

    // a new result always comes from a stepped item
    `TGR_ASSERT_SAME(a_result_from_item, $rose(m_valid_reg), $past(in_valid_reg),
                     "result appeared without an item in the input register")

    // a release always ends the touch and its repeats
    `TGR_ASSERT_NEXT(a_release_clears, proc_fire && !in_touch_reg,
                     !touch_active_reg && !repeat_active_reg,
                     "release did not clear touch state")

endmodule
